/* design/sorted_value_list_core_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sorted value list
// Shared property wrappers used by the checker module.
// ----------------------------------------------------------------------------
`ifndef SORTED_VALUE_LIST_CORE_MACROS_SVH
`define SORTED_VALUE_LIST_CORE_MACROS_SVH

// Checked at every rising clock edge outside reset.
`define SVL_ASSERT(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked at every rising clock edge, reset included.
`define SVL_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/svl_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted value list package
// Types, operation codes and status codes shared by the list modules.
// ----------------------------------------------------------------------------
package svl_pkg;

  localparam int unsigned VALUE_W       = 32;
  localparam int unsigned ENTRY_COUNT_W = 5;

  typedef logic signed [VALUE_W-1:0] entry_t;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_DUMP   = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_EMPTY     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_REMOVE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_cmd_e;

  // Broadcast from the controller to every cell of the chain.
  typedef struct packed {
    cell_cmd_e cmd;
    entry_t    key;
    entry_t    head;
  } svl_ctrl_t;

endpackage

/* design/svl_cell.sv */
// ----------------------------------------------------------------------------
// Sorted value list cell
// Holds one entry and its valid bit; shifts toward either neighbor.
// ----------------------------------------------------------------------------
module svl_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  svl_pkg::svl_ctrl_t ctrl_i,
  input  svl_pkg::entry_t   left_entry_i,
  input  logic              left_valid_i,
  input  logic              left_lt_i,
  input  svl_pkg::entry_t   right_entry_i,
  input  logic              right_valid_i,
  output svl_pkg::entry_t   entry_o,
  output logic              valid_o,
  output logic              lt_o,
  output logic              first_eq_o
);
  import svl_pkg::*;

  entry_t entry_q, entry_d;
  logic   valid_q, valid_d;
  logic   lt;

  assign lt         = valid_q && (entry_q < ctrl_i.key);
  assign lt_o       = lt;
  // The first equal entry sits right after the last smaller one.
  assign first_eq_o = valid_q && (entry_q == ctrl_i.key) && left_lt_i;
  assign entry_o    = entry_q;
  assign valid_o    = valid_q;

  always_comb begin
    entry_d = entry_q;
    valid_d = valid_q;
    unique case (ctrl_i.cmd)
      CELL_INSERT: begin
        valid_d = left_valid_i;
        if (!lt) begin
          entry_d = left_lt_i ? ctrl_i.key : left_entry_i;
        end
      end
      CELL_REMOVE: begin
        if (!lt) begin
          entry_d = right_entry_i;
          valid_d = right_valid_i;
        end
      end
      CELL_ROTATE: begin
        // The last valid cell takes the head so that the list wraps around.
        if (valid_q) begin
          entry_d = right_valid_i ? right_entry_i : ctrl_i.head;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

endmodule

/* design/sorted_value_list_core.sv */
// ----------------------------------------------------------------------------
// Sorted value list core
// Bounded ascending list of signed values held in a chain of cells.
// ----------------------------------------------------------------------------
// Input items arrive on s_axis: tdata carries op and value. Output items
// leave on m_axis: tdata carries status, item_value and entry_count, and
// tlast marks the final result of an input item.
// An insert or remove is decided in the cycle it is accepted: every cell
// compares its entry with the value at once and, unless the status is full,
// empty or not found, the chain shifts by one place. Its single result
// appears on m_axis in the cycle after it is accepted. A dump emits the head
// of the chain and rotates it by one place per cycle while the output is not
// stalled, so a list of N entries comes back in order after N rotations. It
// holds s_axis_tready_o low, unlike an insert or remove, until it has formed
// its last result; a dump of an empty list gives one empty result only.
// Code 3 is dropped without a result.
// While the output register holds an item that the receiver does not take,
// s_axis_tready_o is low and the chain holds still.
// Reset empties the list and clears the output valid at once.
// ----------------------------------------------------------------------------
module sorted_value_list_core #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // op[1:0], value[33:2], zero pad
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // status[1:0], item_value[33:2],
                                        // entry_count[38:34], zero pad
  output logic        m_axis_tlast_o
);
  import svl_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  entry_t     entry_w    [CAPACITY];
  logic       valid_w    [CAPACITY];
  logic       lt_w       [CAPACITY];
  logic [CAPACITY-1:0] first_eq_w;
  svl_ctrl_t  ctrl;

  logic [1:0] in_op;
  entry_t     in_value;
  logic       s_fire, out_free, full, found;
  entry_t     head_min;

  logic [CNT_W-1:0] count_q, count_d;
  logic             busy_q, busy_d;
  logic [CNT_W-1:0] left_q, left_d;

  logic             res_valid;
  status_e          res_status;
  entry_t           res_value;
  logic [CNT_W-1:0] res_count;
  logic             res_last;

  logic                     m_valid_q;
  status_e                  m_status_q;
  entry_t                   m_value_q;
  logic [ENTRY_COUNT_W-1:0] m_count_q;
  logic                     m_last_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t l_entry, r_entry;
    logic   l_valid, l_lt, r_valid;
    if (i == 0) begin : g_first
      assign l_entry = '0;
      assign l_valid = 1'b1;
      assign l_lt    = 1'b1;
    end else begin : g_mid
      assign l_entry = entry_w[i-1];
      assign l_valid = valid_w[i-1];
      assign l_lt    = lt_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign r_entry = '0;
      assign r_valid = 1'b0;
    end else begin : g_inner
      assign r_entry = entry_w[i+1];
      assign r_valid = valid_w[i+1];
    end
    svl_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .ctrl_i       (ctrl),
      .left_entry_i (l_entry),
      .left_valid_i (l_valid),
      .left_lt_i    (l_lt),
      .right_entry_i(r_entry),
      .right_valid_i(r_valid),
      .entry_o      (entry_w[i]),
      .valid_o      (valid_w[i]),
      .lt_o         (lt_w[i]),
      .first_eq_o   (first_eq_w[i])
    );
  end

  assign in_op    = s_axis_tdata_i[1:0];
  assign in_value = s_axis_tdata_i[33:2];

  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !busy_q && out_free;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign full            = (count_q == CNT_W'(CAPACITY));
  assign found           = |first_eq_w;
  assign head_min        = valid_w[0] ? entry_w[0] : '0;

  always_comb begin
    ctrl.cmd   = CELL_HOLD;
    ctrl.key   = in_value;
    ctrl.head  = entry_w[0];
    res_valid  = 1'b0;
    res_status = ST_DONE;
    res_value  = '0;
    res_count  = count_q;
    res_last   = 1'b1;
    count_d    = count_q;
    busy_d     = busy_q;
    left_d     = left_q;
    if (s_fire) begin
      unique case (in_op)
        OP_INSERT: begin
          res_valid = 1'b1;
          if (full) begin
            res_status = ST_FULL;
            res_value  = head_min;
          end else begin
            ctrl.cmd  = CELL_INSERT;
            count_d   = count_q + CNT_W'(1);
            res_count = count_d;
            res_value = lt_w[0] ? entry_w[0] : in_value;
          end
        end
        OP_REMOVE: begin
          res_valid = 1'b1;
          if (count_q == '0) begin
            res_status = ST_EMPTY;
          end else if (!found) begin
            res_status = ST_NOT_FOUND;
            res_value  = head_min;
          end else begin
            ctrl.cmd  = CELL_REMOVE;
            count_d   = count_q - CNT_W'(1);
            res_count = count_d;
            if (lt_w[0]) begin
              res_value = entry_w[0];
            end else if (valid_w[1]) begin
              res_value = entry_w[1];
            end
          end
        end
        OP_DUMP: begin
          if (count_q == '0) begin
            res_valid  = 1'b1;
            res_status = ST_EMPTY;
          end else begin
            busy_d = 1'b1;
            left_d = count_q;
          end
        end
        default: begin
        end
      endcase
    end else if (busy_q && out_free) begin
      ctrl.cmd  = CELL_ROTATE;
      res_valid = 1'b1;
      res_value = entry_w[0];
      res_last  = (left_q == CNT_W'(1));
      left_d    = left_q - CNT_W'(1);
      if (left_q == CNT_W'(1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      busy_q    <= 1'b0;
      left_q    <= '0;
      m_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      busy_q  <= busy_d;
      left_q  <= left_d;
      if (out_free) begin
        m_valid_q <= res_valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_free && res_valid) begin
      m_status_q <= res_status;
      m_value_q  <= res_value;
      m_count_q  <= ENTRY_COUNT_W'(res_count);
      m_last_q   <= res_last;
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_count_q, m_value_q, m_status_q};
  assign m_axis_tlast_o  = m_last_q;

endmodule

/* design/svl_checker.sv */
// ----------------------------------------------------------------------------
// Sorted value list checker
// Port-level assertions on the list core, bound to its top level.
// ----------------------------------------------------------------------------
`include "sorted_value_list_core_macros.svh"

module svl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_tready_i,
  input logic        m_tvalid_i,
  input logic        m_tready_i,
  input logic [39:0] m_tdata_i,
  input logic        m_tlast_i
);
  import svl_pkg::*;

  logic [1:0] status_w;
  logic       empty_w, done_w, zero_fields_w;

  assign status_w      = m_tdata_i[1:0];
  assign empty_w       = (status_w == ST_EMPTY);
  assign done_w        = (status_w == ST_DONE);
  assign zero_fields_w = (m_tdata_i[38:2] == '0);

  `SVL_ASSERT_ALWAYS(a_idle_in_reset, clk_i, !rst_ni |-> !m_tvalid_i, "output valid during reset")
  `SVL_ASSERT(a_hold_on_stall, clk_i, rst_ni, m_tvalid_i && !m_tready_i |=> m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i), "stalled output item changed")
  `SVL_ASSERT(a_no_accept_on_stall, clk_i, rst_ni, m_tvalid_i && !m_tready_i |-> !s_tready_i, "input taken while output stalled")
  `SVL_ASSERT(a_empty_fields, clk_i, rst_ni, m_tvalid_i && empty_w |-> zero_fields_w && m_tlast_i, "empty status with nonzero fields")
  `SVL_ASSERT(a_mid_dump_done, clk_i, rst_ni, m_tvalid_i && !m_tlast_i |-> done_w, "non-final dump item without done status")

endmodule

bind sorted_value_list_core svl_checker u_svl_checker (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .s_tready_i(s_axis_tready_o),
  .m_tvalid_i(m_axis_tvalid_o),
  .m_tready_i(m_axis_tready_i),
  .m_tdata_i (m_axis_tdata_o),
  .m_tlast_i (m_axis_tlast_o)
);

/* dv/sorted_value_list_core_tb.sv */
// ----------------------------------------------------------------------------
// Sorted value list core testbench
// Drives insert, remove, dump and unused-code items into the list core under
// random stalls on both streams. A shadow copy of the list predicts every
// result item, and the monitor checks each one field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_value_list_core_tb;
  import svl_pkg::*;

  localparam int unsigned CAP          = 16;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SETTLE_CYCLE = 20;
  localparam int unsigned RANDOM_ITEMS = 270;
  localparam logic [1:0]  OP_UNUSED    = 2'd3;

  typedef struct {
    logic [1:0] op;
    entry_t     value;
    bit         wait_for_drain;
  } list_req_t;

  typedef struct {
    status_e    status;
    entry_t     value;
    logic [4:0] count;
    logic       last;
  } list_resp_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_valid;
  logic        s_ready;
  logic [39:0] s_data;   // op[1:0], value[33:2], zero pad
  logic        m_valid;
  logic        m_ready;
  logic [39:0] m_data;   // status[1:0], item_value[33:2], entry_count[38:34], zero pad
  logic        m_last;

  list_req_t  req_backlog[$];
  list_resp_t due_results[$];
  list_req_t  req_on_bus;
  logic       req_taken;

  entry_t sorted_shadow[CAP];
  int     held_shadow;

  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned items_sent;
  int unsigned results_checked;
  int unsigned ops_taken[4];
  int unsigned full_drops;

  entry_t value_pool[8];

  sorted_value_list_core #(
    .CAPACITY(CAP)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data),
    .m_axis_tlast_o (m_last)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Neither side idles while this stretch of items is on the bus.
  function automatic bit no_idle_stretch();
    return items_sent >= 140 && items_sent < 200;
  endfunction

  // ---------------------------------------------------------------------------
  // Shadow list
  // ---------------------------------------------------------------------------
  function automatic void post_result(status_e st, entry_t val, int cnt, logic lst);
    list_resp_t r;
    r.status = st;
    r.value  = val;
    r.count  = cnt[4:0];
    r.last   = lst;
    due_results.push_back(r);
  endfunction

  function automatic entry_t shadow_min();
    return (held_shadow > 0) ? sorted_shadow[0] : entry_t'(0);
  endfunction

  function automatic void apply_list_op(list_req_t req);
    int p;
    int k;
    p = 0;
    case (req.op)
      OP_INSERT: begin
        if (held_shadow >= CAP) begin
          full_drops++;
          post_result(ST_FULL, shadow_min(), held_shadow, 1'b1);
        end else begin
          // Equal values go after the entries already held.
          while (p < held_shadow && sorted_shadow[p] <= req.value) p++;
          for (k = held_shadow; k > p; k--) sorted_shadow[k] = sorted_shadow[k-1];
          sorted_shadow[p] = req.value;
          held_shadow++;
          post_result(ST_DONE, shadow_min(), held_shadow, 1'b1);
        end
      end
      OP_REMOVE: begin
        if (held_shadow == 0) begin
          post_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          while (p < held_shadow && sorted_shadow[p] != req.value) p++;
          if (p >= held_shadow) begin
            post_result(ST_NOT_FOUND, shadow_min(), held_shadow, 1'b1);
          end else begin
            for (k = p; k + 1 < held_shadow; k++) sorted_shadow[k] = sorted_shadow[k+1];
            held_shadow--;
            sorted_shadow[held_shadow] = '0;
            post_result(ST_DONE, shadow_min(), held_shadow, 1'b1);
          end
        end
      end
      OP_DUMP: begin
        if (held_shadow == 0) begin
          post_result(ST_EMPTY, '0, 0, 1'b1);
        end else begin
          for (k = 0; k < held_shadow; k++) begin
            post_result(ST_DONE, sorted_shadow[k], held_shadow, k + 1 == held_shadow);
          end
        end
      end
      default: begin
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: both streams change on the falling edge.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    logic        nxt_valid;
    logic [39:0] nxt_data;
    bit          calm;
    nxt_valid = s_valid;
    nxt_data  = s_data;
    calm      = no_idle_stretch();
    if (!rst_ni) begin
      nxt_valid = 1'b0;
    end else if (!s_valid || req_taken) begin
      nxt_valid = 1'b0;
      if (req_backlog.size() != 0 &&
          !(req_backlog[0].wait_for_drain && due_results.size() != 0) &&
          (calm || $urandom_range(99) >= 35)) begin
        req_on_bus = req_backlog.pop_front();
        nxt_valid  = 1'b1;
        nxt_data   = {6'd0, req_on_bus.value, req_on_bus.op};
        items_sent++;
      end
    end
    s_valid <= nxt_valid;
    s_data  <= nxt_data;
    m_ready <= rst_ni && (calm || $urandom_range(99) >= 35);
  end

  // ---------------------------------------------------------------------------
  // Monitor: both streams are sampled on the rising edge.
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    list_resp_t want;
    logic [1:0] got_status;
    entry_t     got_value;
    logic [4:0] got_count;
    cycle_cnt <= cycle_cnt + 1;
    if (!rst_ni) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= s_valid && s_ready;
      if (s_valid && s_ready) begin
        ops_taken[req_on_bus.op]++;
        apply_list_op(req_on_bus);
      end
      if (m_valid && m_ready) begin
        got_status = m_data[1:0];
        got_value  = m_data[33:2];
        got_count  = m_data[38:34];
        if (due_results.size() == 0) begin
          $error("unexpected result item: status %0d value %0d count %0d last %0b",
                 got_status, got_value, got_count, m_last);
          err_cnt++;
        end else begin
          want = due_results.pop_front();
          results_checked++;
          if (got_status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got_status);
            err_cnt++;
          end
          if (got_value !== want.value) begin
            $error("item_value: expected %0d, got %0d", want.value, got_value);
            err_cnt++;
          end
          if (got_count !== want.count) begin
            $error("entry_count: expected %0d, got %0d", want.count, got_count);
            err_cnt++;
          end
          if (m_last !== want.last) begin
            $error("last: expected %0b, got %0b", want.last, m_last);
            err_cnt++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic void queue_req(logic [1:0] op, entry_t value, bit wait_for_drain = 0);
    list_req_t r;
    r.op             = op;
    r.value          = value;
    r.wait_for_drain = wait_for_drain;
    req_backlog.push_back(r);
  endfunction

  // Pool values make removes hit and inserts pile up duplicates.
  function automatic entry_t pick_value();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 60) return value_pool[$urandom_range(7)];
    if (r < 70) return value_pool[$urandom_range(3)];
    return entry_t'($urandom);
  endfunction

  initial begin
    int unsigned n;
    int unsigned r;
    bit          filling;
    logic [1:0]  op;

    rst_ni          = 1'b0;
    s_valid         = 1'b0;
    s_data          = '0;
    m_ready         = 1'b0;
    req_taken       = 1'b0;
    req_on_bus      = '{op: OP_UNUSED, value: '0, wait_for_drain: 0};
    held_shadow     = 0;
    cycle_cnt       = 0;
    err_cnt         = 0;
    items_sent      = 0;
    results_checked = 0;
    full_drops      = 0;
    foreach (ops_taken[i]) ops_taken[i] = 0;
    foreach (sorted_shadow[i]) sorted_shadow[i] = '0;

    value_pool[0] = 32'sh7FFF_FFFF;
    value_pool[1] = 32'sh8000_0000;
    value_pool[2] = '0;
    value_pool[3] = -32'sd1;
    for (n = 4; n < 8; n++) value_pool[n] = entry_t'($urandom);

    // Directed part: empty cases, extremes, duplicates, a miss, the unused
    // code, then a fill to capacity, two dropped inserts and a full dump.
    queue_req(OP_DUMP, '0);
    queue_req(OP_REMOVE, '0);
    queue_req(OP_INSERT, 32'sh7FFF_FFFF);
    queue_req(OP_REMOVE, 32'sh7FFF_FFFF);
    queue_req(OP_INSERT, 32'sh8000_0000);
    queue_req(OP_INSERT, '0);
    queue_req(OP_INSERT, -32'sd1);
    queue_req(OP_INSERT, -32'sd1);
    queue_req(OP_DUMP, 32'sh5A5A_A5A5);
    queue_req(OP_REMOVE, 32'sd5);
    queue_req(OP_REMOVE, -32'sd1);
    queue_req(OP_UNUSED, 32'shFFFF_FFFF);
    for (n = 0; n < 14; n++) queue_req(OP_INSERT, value_pool[n % 8]);
    queue_req(OP_INSERT, 32'sh1234_5678);
    queue_req(OP_DUMP, '0, 1);

    // Random part: alternating drain and fill phases sweep the count between
    // empty and full; the list starts full here, so draining comes first.
    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (n % 50 == 49) begin
        for (r = 4; r < 8; r++) value_pool[r] = entry_t'($urandom);
      end
      filling = ((n / 40) % 2) == 1;
      r = $urandom_range(99);
      if (r < 3) begin
        queue_req(OP_UNUSED, entry_t'($urandom));
        continue;
      end
      if (r < 12) op = OP_DUMP;
      else if ($urandom_range(99) < (filling ? 70 : 30)) op = OP_INSERT;
      else op = OP_REMOVE;
      queue_req(op, pick_value(), n % 75 == 74);
      n++;
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_backlog.size() != 0 || s_valid || due_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLE) @(posedge clk_i);

    $display("Items taken: %0d inserts (%0d on a full list), %0d removes, %0d dumps, %0d unused",
             ops_taken[OP_INSERT], full_drops, ops_taken[OP_REMOVE], ops_taken[OP_DUMP],
             ops_taken[OP_UNUSED]);
    $display("Result items checked: %0d in %0d cycles", results_checked, cycle_cnt);
    if (err_cnt == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Watchdog on the cycle counter.
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

endmodule
